[rtl/core/gso_pkg.sv]
// gso_pkg: widths, latencies, item record and rounding helpers for the
// 3x3 modified Gram-Schmidt pipeline. Depends on nothing; every rtl/core
// module imports it.
package gso_pkg;

    // Number formats
    localparam int OUT_FRAC_BITS = 30;
    localparam int NCOMP         = 3;
    localparam int IN_W          = 32;
    localparam int WW            = IN_W + 1;                 // working column component
    localparam int MAG_W         = IN_W;                     // |w| after clamping
    localparam int SQ_W          = 2 * MAG_W;                // squared norm
    localparam int UW            = OUT_FRAC_BITS + 2;        // signed unit component
    localparam int QW            = OUT_FRAC_BITS + 1;        // unsigned quotient
    localparam int NUM_W         = MAG_W + OUT_FRAC_BITS + 1; // dividend
    localparam int PROD_W        = WW + UW;                  // w * u
    localparam int DOT_W         = 64;                       // saturated dot product
    localparam int RS_W          = DOT_W + 1 - OUT_FRAC_BITS; // rounded shift result
    localparam int DW            = IN_W + 2;                 // clamped projection length
    localparam int PD_W          = DW + UW;                  // d * u
    localparam int DIFF_W        = RS_W + 1;                 // w minus projection

    localparam logic signed [RS_W-1:0]   DOT_LIM  = RS_W'((65'd1 << (DW - 1)) - 65'd1);
    localparam logic signed [DIFF_W-1:0] WORK_LIM = DIFF_W'((65'd1 << (WW - 1)) - 65'd1);

    // Pipeline depths
    localparam int NRM_STEPS = 5;                        // binary search of the even shift
    localparam int PRE_LAT   = 2 + NRM_STEPS;            // square, sum, normalize
    localparam int SQ_STEPS  = MAG_W;                    // one root bit per stage
    localparam int DIV_STEPS = QW;                       // one quotient bit per stage
    localparam int NORM_LAT  = PRE_LAT + SQ_STEPS + DIV_STEPS;
    localparam int PRJ_LAT   = 5;

    // Column selectors
    typedef logic [1:0] t_col;
    localparam t_col COL0 = 2'd0;
    localparam t_col COL1 = 2'd1;
    localparam t_col COL2 = 2'd2;

    // One matrix in flight: working columns, unit columns, degenerate flag
    typedef struct packed {
        logic                                deg;
        logic [NCOMP-1:0][NCOMP-1:0][WW-1:0] w;
        logic [NCOMP-1:0][NCOMP-1:0][UW-1:0] u;
    } t_item;

    // Shift right by OUT_FRAC_BITS, rounding half away from zero
    function automatic logic signed [RS_W-1:0] round_shr(input logic signed [DOT_W-1:0] v);
        logic [DOT_W-1:0] m;
        logic [DOT_W:0]   t;
        logic [RS_W-1:0]  r;
        m = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
        t = {1'b0, m} + ((DOT_W+1)'(1) << (OUT_FRAC_BITS - 1));
        r = RS_W'(t >> OUT_FRAC_BITS);
        return v[DOT_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

[rtl/core/gram_schmidt_orthonormalize_3x3.sv]
// gram_schmidt_orthonormalize_3x3: top level of the 3x3 modified
// Gram-Schmidt pipeline. Depends on gso_pkg, gso_col_norm, gso_project.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------------------
//   input    | i_in_valid   | o_in_stall   | i_in_c0_x .. i_in_c2_z (Q15.16)
//   output   | o_out_valid  | i_out_stall  | o_out_c0_x .. o_out_c2_z (Q1.30),
//            |              |              | o_degenerate
//
// One item enters per cycle unless o_in_stall is high; per column 70 stages
// (square, sum, 5 shift steps, 32 root stages, 31 divide stages), plus 5
// projection stages after columns 0 and 1.
// Reset clears the valid bits only. While the output item is held by
// i_out_stall the whole pipeline holds and o_in_stall is raised.
module gram_schmidt_orthonormalize_3x3
    import gso_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [31:0]   i_in_c0_x,
    input  logic signed [31:0]   i_in_c0_y,
    input  logic signed [31:0]   i_in_c0_z,
    input  logic signed [31:0]   i_in_c1_x,
    input  logic signed [31:0]   i_in_c1_y,
    input  logic signed [31:0]   i_in_c1_z,
    input  logic signed [31:0]   i_in_c2_x,
    input  logic signed [31:0]   i_in_c2_y,
    input  logic signed [31:0]   i_in_c2_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_out_c0_x,
    output logic signed [31:0]   o_out_c0_y,
    output logic signed [31:0]   o_out_c0_z,
    output logic signed [31:0]   o_out_c1_x,
    output logic signed [31:0]   o_out_c1_y,
    output logic signed [31:0]   o_out_c1_z,
    output logic signed [31:0]   o_out_c2_x,
    output logic signed [31:0]   o_out_c2_y,
    output logic signed [31:0]   o_out_c2_z,
    output logic                 o_degenerate
);

    logic  adv;
    t_item in_item;
    logic  v_n0, v_p0, v_n1, v_p1, v_n2;
    t_item i_n0, i_p0, i_n1, i_p1, i_n2;

    // Advance whenever the output stage is free or being taken
    assign adv        = !(v_n2 && i_out_stall);
    assign o_in_stall = !adv;

    // Build the entry item
    always_comb begin
        in_item         = '0;
        in_item.w[0][0] = WW'(i_in_c0_x);
        in_item.w[0][1] = WW'(i_in_c0_y);
        in_item.w[0][2] = WW'(i_in_c0_z);
        in_item.w[1][0] = WW'(i_in_c1_x);
        in_item.w[1][1] = WW'(i_in_c1_y);
        in_item.w[1][2] = WW'(i_in_c1_z);
        in_item.w[2][0] = WW'(i_in_c2_x);
        in_item.w[2][1] = WW'(i_in_c2_y);
        in_item.w[2][2] = WW'(i_in_c2_z);
    end

    gso_col_norm u_norm0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (adv),
        .i_valid (i_in_valid), .i_col (COL0), .i_item (in_item),
        .o_valid (v_n0), .o_item (i_n0)
    );

    gso_project u_proj0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (adv),
        .i_valid (v_n0), .i_col (COL0), .i_item (i_n0),
        .o_valid (v_p0), .o_item (i_p0)
    );

    gso_col_norm u_norm1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (adv),
        .i_valid (v_p0), .i_col (COL1), .i_item (i_p0),
        .o_valid (v_n1), .o_item (i_n1)
    );

    gso_project u_proj1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (adv),
        .i_valid (v_n1), .i_col (COL1), .i_item (i_n1),
        .o_valid (v_p1), .o_item (i_p1)
    );

    gso_col_norm u_norm2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_adv (adv),
        .i_valid (v_p1), .i_col (COL2), .i_item (i_p1),
        .o_valid (v_n2), .o_item (i_n2)
    );

    // Drive the result item
    assign o_out_valid  = v_n2;
    assign o_out_c0_x   = $signed(i_n2.u[0][0]);
    assign o_out_c0_y   = $signed(i_n2.u[0][1]);
    assign o_out_c0_z   = $signed(i_n2.u[0][2]);
    assign o_out_c1_x   = $signed(i_n2.u[1][0]);
    assign o_out_c1_y   = $signed(i_n2.u[1][1]);
    assign o_out_c1_z   = $signed(i_n2.u[1][2]);
    assign o_out_c2_x   = $signed(i_n2.u[2][0]);
    assign o_out_c2_y   = $signed(i_n2.u[2][1]);
    assign o_out_c2_z   = $signed(i_n2.u[2][2]);
    assign o_degenerate = i_n2.deg;

endmodule

[rtl/core/gso_sqrt.sv]
// gso_sqrt: pipelined integer square root of a normalized 64-bit radicand,
// one root bit per stage. Depends on gso_pkg.
module gso_sqrt
    import gso_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [SQ_W-1:0]  i_rad,
    output logic [MAG_W-1:0] o_root
);

    logic [SQ_W-1:0] r_v   [SQ_STEPS];
    logic [SQ_W-1:0] r_res [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
        logic [SQ_W-1:0] v_in, res_in, trial, n_v, n_res;

        if (g == 0) begin : g_first
            assign v_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign res_in = r_res[g-1];
        end

        // Try the next root bit
        always_comb begin
            trial = res_in + BIT;
            if (v_in >= trial) begin
                n_v   = v_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_v   = v_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_v[g]   <= n_v;
                r_res[g] <= n_res;
            end
        end
    end

    assign o_root = r_res[SQ_STEPS-1][MAG_W-1:0];

endmodule

[rtl/core/gso_div_lane.sv]
// gso_div_lane: pipelined restoring divider for one vector component,
// one quotient bit per stage. Depends on gso_pkg.
module gso_div_lane
    import gso_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [NUM_W-1:0] i_num,
    input  logic [MAG_W-1:0] i_den,
    output logic [QW-1:0]    o_quo
);

    logic [NUM_W-1:0] r_rem [DIV_STEPS];
    logic [MAG_W-1:0] r_den [DIV_STEPS];
    logic [QW-1:0]    r_quo [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        localparam int BITPOS = QW - 1 - g;
        logic [NUM_W-1:0] rem_in, trial, n_rem;
        logic [MAG_W-1:0] den_in;
        logic [QW-1:0]    quo_in, n_quo;

        if (g == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        // Subtract the shifted divisor when it fits
        always_comb begin
            trial = NUM_W'(den_in) << BITPOS;
            if (rem_in >= trial) begin
                n_rem = rem_in - trial;
                n_quo = quo_in | (QW'(1) << BITPOS);
            end else begin
                n_rem = rem_in;
                n_quo = quo_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_quo[g] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

[rtl/core/gso_col_norm.sv]
// gso_col_norm: scales one column of the item to unit length (squares per
// lane, merged sum, even normalizing shift, root, three divider lanes).
// Depends on gso_pkg, gso_sqrt and gso_div_lane.
module gso_col_norm
    import gso_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_col  i_col,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_item [NORM_LAT];
    logic [NORM_LAT-1:0] r_vld;

    logic [MAG_W-1:0]  mag   [NCOMP];
    logic [SQ_W-1:0]   sq    [NCOMP];
    logic [MAG_W-1:0]  r_mag [NCOMP];
    logic [SQ_W-1:0]   r_sq  [NCOMP];
    logic [SQ_W+1:0]   sum;
    logic [SQ_W-1:0]   r_s;
    logic [MAG_W-1:0]  r_mag2 [NCOMP];

    logic [SQ_W-1:0]   r_ns [NRM_STEPS];
    logic [MAG_W-1:0]  r_nm [NRM_STEPS][NCOMP];
    logic [MAG_W-1:0]  r_md [SQ_STEPS][NCOMP];

    logic [MAG_W-1:0]  root;
    logic [QW-1:0]     quo [NCOMP];
    logic              zero;

    // Valid and item delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NORM_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item[0] <= i_item;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_item[i] <= r_item[i-1];
            end
        end
    end

    // Lanes: magnitude and square of each component
    always_comb begin
        logic signed [WW-1:0] wk;
        for (int k = 0; k < NCOMP; k++) begin
            wk     = $signed(i_item.w[i_col][k]);
            mag[k] = wk[WW-1] ? MAG_W'(-wk) : MAG_W'(wk);
            sq[k]  = mag[k] * mag[k];
        end
    end

    // Merge: saturating sum of squares
    assign sum = (SQ_W+2)'(r_sq[0]) + (SQ_W+2)'(r_sq[1]) + (SQ_W+2)'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < NCOMP; k++) begin
                r_mag[k]  <= mag[k];
                r_sq[k]   <= sq[k];
                r_mag2[k] <= r_mag[k];
            end
            r_s <= (sum[SQ_W+1:SQ_W] != 2'b00) ? '1 : sum[SQ_W-1:0];
        end
    end

    // Normalize: shift by an even amount until bit 62 or 63 is set
    for (genvar g = 0; g < NRM_STEPS; g++) begin : g_nrm
        localparam int SH = 1 << (NRM_STEPS - 1 - g);
        logic [SQ_W-1:0]  s_in;
        logic [MAG_W-1:0] m_in [NCOMP];

        if (g == 0) begin : g_first
            assign s_in = r_s;
            assign m_in = r_mag2;
        end else begin : g_next
            assign s_in = r_ns[g-1];
            assign m_in = r_nm[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (s_in[SQ_W-1 -: 2*SH] == '0) begin
                    r_ns[g] <= s_in << (2 * SH);
                    for (int k = 0; k < NCOMP; k++) begin
                        r_nm[g][k] <= m_in[k] << SH;
                    end
                end else begin
                    r_ns[g] <= s_in;
                    r_nm[g] <= m_in;
                end
            end
        end
    end

    // Root of the normalized sum; scaled magnitudes ride alongside
    gso_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_adv  (i_adv),
        .i_rad  (r_ns[NRM_STEPS-1]),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_md[0] <= r_nm[NRM_STEPS-1];
            for (int i = 1; i < SQ_STEPS; i++) begin
                r_md[i] <= r_md[i-1];
            end
        end
    end

    // Divider lanes: u = (m << OUT_FRAC_BITS + n/2) / n
    for (genvar k = 0; k < NCOMP; k++) begin : g_lane
        logic [NUM_W-1:0] num;
        assign num = (NUM_W'(r_md[SQ_STEPS-1][k]) << OUT_FRAC_BITS) + NUM_W'(root >> 1);

        gso_div_lane u_div (
            .i_clk (i_clk),
            .i_adv (i_adv),
            .i_num (num),
            .i_den (root),
            .o_quo (quo[k])
        );
    end

    // Write back the unit column; an all-zero column gives zeros and the flag
    assign zero = (r_item[NORM_LAT-1].w[i_col] == '0);

    always_comb begin
        o_item     = r_item[NORM_LAT-1];
        o_item.deg = r_item[NORM_LAT-1].deg | zero;
        for (int k = 0; k < NCOMP; k++) begin
            if (zero) begin
                o_item.u[i_col][k] = '0;
            end else if (r_item[NORM_LAT-1].w[i_col][k][WW-1]) begin
                o_item.u[i_col][k] = UW'(-$signed({1'b0, quo[k]}));
            end else begin
                o_item.u[i_col][k] = UW'(quo[k]);
            end
        end
    end

    assign o_valid = r_vld[NORM_LAT-1];

endmodule

[rtl/core/gso_project.sv]
// gso_project: removes the projection on one unit column from every later
// working column (lane products, merged dot, rescale, subtract).
// Depends on gso_pkg.
module gso_project
    import gso_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_col  i_col,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    t_item               r_item [PRJ_LAT];
    logic [PRJ_LAT-1:0]  r_vld;

    logic signed [PROD_W-1:0] r_prod [NCOMP][NCOMP];
    logic signed [DOT_W-1:0]  r_dot  [NCOMP];
    logic signed [DW-1:0]     r_d    [NCOMP];
    logic signed [PD_W-1:0]   r_pd   [NCOMP][NCOMP];

    logic signed [PROD_W+1:0] dsum [NCOMP];
    logic signed [RS_W-1:0]   drs  [NCOMP];
    t_item                    n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[PRJ_LAT-2:0], i_valid};
        end
    end

    // Merge: dot sums saturated to 64 bits, then rounded and clamped
    always_comb begin
        for (int j = 0; j < NCOMP; j++) begin
            dsum[j] = (PROD_W+2)'(r_prod[j][0]) + (PROD_W+2)'(r_prod[j][1])
                    + (PROD_W+2)'(r_prod[j][2]);
            drs[j]  = round_shr(r_dot[j]);
        end
    end

    // Subtract d * u from every later column, clamp
    always_comb begin
        logic signed [RS_W-1:0]   p;
        logic signed [DIFF_W-1:0] diff;
        n_last = r_item[PRJ_LAT-2];
        for (int j = 0; j < NCOMP; j++) begin
            for (int k = 0; k < NCOMP; k++) begin
                p    = round_shr(DOT_W'(r_pd[j][k]));
                diff = DIFF_W'($signed(r_item[PRJ_LAT-2].w[j][k])) - DIFF_W'(p);
                if (diff > WORK_LIM) begin
                    diff = WORK_LIM;
                end else if (diff < -WORK_LIM) begin
                    diff = -WORK_LIM;
                end
                if (t_col'(j) > i_col) begin
                    n_last.w[j][k] = WW'(diff);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item[0] <= i_item;
            for (int i = 1; i < PRJ_LAT - 1; i++) begin
                r_item[i] <= r_item[i-1];
            end
            r_item[PRJ_LAT-1] <= n_last;

            for (int j = 0; j < NCOMP; j++) begin
                // Lanes: w * u
                for (int k = 0; k < NCOMP; k++) begin
                    r_prod[j][k] <= PROD_W'($signed(i_item.w[j][k]))
                                  * PROD_W'($signed(i_item.u[i_col][k]));
                end
                // Saturate the dot
                if (dsum[j][PROD_W+1:DOT_W-1] == '0 || dsum[j][PROD_W+1:DOT_W-1] == '1) begin
                    r_dot[j] <= DOT_W'(dsum[j]);
                end else if (dsum[j][PROD_W+1]) begin
                    r_dot[j] <= {1'b1, {(DOT_W-1){1'b0}}};
                end else begin
                    r_dot[j] <= {1'b0, {(DOT_W-1){1'b1}}};
                end
                // Round and clamp the projection length
                if (drs[j] > DOT_LIM) begin
                    r_d[j] <= DW'(DOT_LIM);
                end else if (drs[j] < -DOT_LIM) begin
                    r_d[j] <= DW'(-DOT_LIM);
                end else begin
                    r_d[j] <= DW'(drs[j]);
                end
                // Lanes: d * u
                for (int k = 0; k < NCOMP; k++) begin
                    r_pd[j][k] <= PD_W'(r_d[j]) * PD_W'($signed(r_item[2].u[i_col][k]));
                end
            end
        end
    end

    assign o_valid = r_vld[PRJ_LAT-1];
    assign o_item  = r_item[PRJ_LAT-1];

endmodule

[tb/tb_gram_schmidt_orthonormalize_3x3.sv]
// Self-checking testbench for the 3x3 modified Gram-Schmidt pipeline.
// Computes the orthonormal columns and the degenerate flag of each matrix in
// bit-exact integer arithmetic. Depends on gso_pkg and the top-level module.
module tb_gram_schmidt_orthonormalize_3x3
    import gso_pkg::*;
();

    typedef struct {
        logic signed [31:0] c[9];
        logic               deg;
    } t_mat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] in_c[9];
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] out_c[9];
    logic o_degenerate;

    t_mat expected_q[$];
    int   n_mismatch = 0;
    bit   idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;

    initial for (int i = 0; i < 9; i++) in_c[i] = '0;

    gram_schmidt_orthonormalize_3x3 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_c0_x(in_c[0]), .i_in_c0_y(in_c[1]), .i_in_c0_z(in_c[2]),
        .i_in_c1_x(in_c[3]), .i_in_c1_y(in_c[4]), .i_in_c1_z(in_c[5]),
        .i_in_c2_x(in_c[6]), .i_in_c2_y(in_c[7]), .i_in_c2_z(in_c[8]),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_c0_x(out_c[0]), .o_out_c0_y(out_c[1]), .o_out_c0_z(out_c[2]),
        .o_out_c1_x(out_c[3]), .o_out_c1_y(out_c[4]), .o_out_c1_z(out_c[5]),
        .o_out_c2_x(out_c[6]), .o_out_c2_y(out_c[7]), .o_out_c2_z(out_c[8]),
        .o_degenerate(o_degenerate)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Round a signed value right by the output fraction width, half away from zero
    function automatic longint shr_round(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Orthonormalize one matrix, column by column
    function automatic t_mat orthonormalize(logic signed [31:0] a[9]);
        t_mat r;
        longint w[9];
        longint u[9];
        longint unsigned s2, sq, m, n, q, rem, bt, res;
        longint dot, d;
        int sh;
        r.deg = 1'b0;
        for (int i = 0; i < 9; i++) w[i] = a[i];
        for (int c = 0; c < 3; c++) begin
            s2 = 0;
            for (int k = 0; k < 3; k++) begin
                m = (w[c*3+k] < 0) ? -w[c*3+k] : w[c*3+k];
                sq = m * m;
                s2 = (s2 > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : s2 + sq;
            end
            if (s2 == 0) begin
                r.deg = 1'b1;
                for (int k = 0; k < 3; k++) u[c*3+k] = 0;
                continue;
            end
            sh = 0;
            while ((s2 >> 62) == 0) begin
                s2 = s2 << 2;
                sh++;
            end
            // integer square root
            rem = s2;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > rem) bt = bt >> 2;
            while (bt != 0) begin
                if (rem >= res + bt) begin
                    rem = rem - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            n = res;
            for (int k = 0; k < 3; k++) begin
                m = ((w[c*3+k] < 0) ? -w[c*3+k] : w[c*3+k]) << sh;
                q = ((m << OUT_FRAC_BITS) + n / 2) / n;
                u[c*3+k] = (w[c*3+k] < 0) ? -longint'(q) : longint'(q);
            end
            // remove the projection from later columns
            for (int j = c + 1; j < 3; j++) begin
                dot = 0;
                for (int k = 0; k < 3; k++) begin
                    longint p;
                    p = w[j*3+k] * u[c*3+k];
                    if (p > 0 && dot > 64'sh7FFF_FFFF_FFFF_FFFF - p)
                        dot = 64'sh7FFF_FFFF_FFFF_FFFF;
                    else if (p < 0 && dot < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - p)
                        dot = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
                    else
                        dot = dot + p;
                end
                d = clamp(shr_round(dot), 64'd8589934591);
                for (int k = 0; k < 3; k++)
                    w[j*3+k] = clamp(w[j*3+k] - shr_round(d * u[c*3+k]), 64'd4294967295);
            end
        end
        for (int i = 0; i < 9; i++) r.c[i] = u[i][31:0];
        return r;
    endfunction

    // Send one item, with random idle cycles before it
    task automatic send_matrix(logic signed [31:0] a[9]);
        while (idle_on && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        for (int i = 0; i < 9; i++) in_c[i] <= a[i];
        expected_q.push_back(orthonormalize(a));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_cols(logic signed [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2);
        logic signed [31:0] a[9];
        a = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
        send_matrix(a);
    endtask

    // Drive the receiver stall at the falling edge
    always @(negedge i_clk)
        i_out_stall <= sink_idle_on && ($urandom_range(99) < 24);

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result item");
            end else begin
                t_mat e;
                bit bad;
                e = expected_q.pop_front();
                bad = (o_degenerate !== e.deg);
                for (int i = 0; i < 9; i++) if (out_c[i] !== e.c[i]) bad = 1'b1;
                if (bad) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("mismatch deg exp %0d got %0d", e.deg, o_degenerate);
                        for (int i = 0; i < 9; i++)
                            $display("  comp %0d exp %h got %h", i, e.c[i], out_c[i]);
                    end
                end
            end
        end
    end

    // Drop valid and wait until every expected result has come
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_cols(65536, 0, 0, 0, 65536, 0, 0, 0, 65536);
        send_cols(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cols(mx, mx, mx, mn, mn, mn, mx, mn, mx);
        send_cols(mn, 0, 0, 0, mn, 0, 0, 0, mn);
        send_cols(mx, mn, mx, mn, mx, mn, 1, -1, 1);
        send_cols(1, 0, 0, 0, 1, 0, 0, 0, 1);
        send_cols(-1, -1, -1, 1, 1, 1, 0, 0, 0);
        send_cols(0, 0, 0, 65536, 65536, 0, 3, 4, 5);
        send_cols(65536, 65536, 0, 65537, 65536, 0, 0, 0, 1);
        send_cols(mx, mx - 1, mx, mx, mx, mx, mn, mn + 1, mn);
        send_cols(3, 4, 0, 6, 8, 0, 9, 12, 1);
        send_cols(-32'sd65536, 2, 0, 5, -7, 11, 0, 0, 0);
        send_cols(12345, -678, 91011, 12345, -678, 91011, -12345, 678, -91011);
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(255)) - 128;
            2: return $urandom >> $urandom_range(31);
            3: return -($urandom >> $urandom_range(31));
            4: return 0;
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    task automatic test_random(int count);
        logic signed [31:0] a[9];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 9; i++) a[i] = rand_comp();
            // nearly dependent or repeated columns
            if ($urandom_range(9) == 0)
                for (int k = 0; k < 3; k++) a[3+k] = a[k] + ($signed($urandom_range(2)) - 1);
            if ($urandom_range(9) == 0)
                for (int k = 0; k < 3; k++) a[6+k] = a[3+k];
            send_matrix(a);
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        sink_idle_on = 1'b0;
        test_random(300);
        idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(350);
        test_drain_pause();
        test_back_to_back();
        test_random(340);
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (n_mismatch == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
